// File: hdl/bwls_pkg.sv
// Shared types, widths and codes for the bigram weighted letter sampler.
package bwls_pkg;

    // Table geometry
    localparam int ALPHABET = 26;
    localparam int ROWS     = ALPHABET + 1;
    localparam int DEPTH    = ROWS * ALPHABET;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int IDX_W    = $clog2(ALPHABET + 1);

    // Field widths
    localparam int WEIGHT_W = 16;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int LETTER_W = 5;
    localparam int RAND_W   = 31;
    localparam int BIT_W    = $clog2(RAND_W);

    // Row total and shared unit word
    localparam int TOT_W = $clog2(ALPHABET * (2**WEIGHT_W - 1) + 1);
    localparam int ALU_W = TOT_W + 1;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [RAND_W-1:0]   t_rand;
    typedef logic [BIT_W-1:0]    t_bit;
    typedef logic [ALU_W-1:0]    t_word;

    localparam t_weight MIN_WEIGHT_RESET = t_weight'(20);
    localparam t_idx    LAST_IDX = t_idx'(ALPHABET - 1);
    localparam t_idx    CNT_END  = t_idx'(ALPHABET);
    localparam t_addr   CLR_LAST = t_addr'(DEPTH - 1);
    localparam t_bit    BIT_LAST = t_bit'(RAND_W - 1);

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        t_word   a;
        t_word   b;
    } t_alu_req;

endpackage

// File: hdl/bwls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bwls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 702
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bwls_alu.sv
// Shared add/subtract unit used for row sum, modulo and running-sum scan.
module bwls_alu (
    input  bwls_pkg::t_alu_req i_req,
    output bwls_pkg::t_word    o_result,
    output logic               o_borrow
);

    logic [bwls_pkg::ALU_W:0] w_ext;

    // Add or subtract with one extra bit for borrow
    always_comb begin
        case (i_req.op)
            bwls_pkg::ALU_ADD: w_ext = {1'b0, i_req.a} + {1'b0, i_req.b};
            bwls_pkg::ALU_SUB: w_ext = {1'b0, i_req.a} - {1'b0, i_req.b};
            default:           w_ext = '0;
        endcase
    end

    assign o_result = w_ext[bwls_pkg::ALU_W-1:0];
    assign o_borrow = (i_req.op == bwls_pkg::ALU_SUB) && w_ext[bwls_pkg::ALU_W];

endmodule

// File: hdl/bigram_weighted_letter_sampler.sv
// Top level: weight table, draw sequencer and result register.
//
// Usage: one input channel (valid/stall) takes load and draw beats; one
// output channel (valid/stall) returns a letter beat per draw. A load
// beat writes one weight (stored as zero when below min_weight) in the
// cycle it is accepted and returns nothing. A draw beat sums the named
// row, reduces random_value modulo the total and scans the row for the
// first letter whose running sum exceeds the remainder.
// Sequence: a draw stalls the input through the row sum, a restoring
// modulo over the RAND_W bits of random_value (one bit per cycle), the
// scan and the final state, which hands the letter to the result
// register. An empty row skips modulo and scan; a row above the table
// goes straight to the final state. Sum, modulo and scan share one
// add/subtract unit; the table's single read port sets the sum and scan.
// Reset: the table is cleared by a pass of all DEPTH (702) words with the
// input stalled; min_weight returns to 20 and accepts writes at any time.
// Output stall: the result register holds the beat; the block accepts the
// next item meanwhile and a later draw waits in its final state.
module bigram_weighted_letter_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bwls_pkg::WEIGHT_W-1:0] i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [bwls_pkg::ROW_W-1:0]    i_row,
    input  logic [bwls_pkg::COL_W-1:0]    i_column,
    input  logic [bwls_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [bwls_pkg::RAND_W-1:0]   i_random_value,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bwls_pkg::LETTER_W-1:0] o_letter,
    output logic                          o_empty_row
);

    bwls_pkg::t_state  r_state, n_state;
    bwls_pkg::t_addr   r_clr_addr, n_clr_addr;
    bwls_pkg::t_addr   r_base, n_base;
    bwls_pkg::t_idx    r_cnt, n_cnt;
    bwls_pkg::t_idx    r_rd_idx, n_rd_idx;
    logic              r_rd_vld, n_rd_vld;
    bwls_pkg::t_word   r_acc, n_acc;
    bwls_pkg::t_word   r_rem, n_rem;
    bwls_pkg::t_rand   r_rnd, n_rnd;
    bwls_pkg::t_bit    r_bit, n_bit;
    bwls_pkg::t_idx    r_pick, n_pick;
    logic              r_empty, n_empty;
    logic              r_out_vld, n_out_vld;
    bwls_pkg::t_letter r_letter, n_letter;
    logic              r_out_empty, n_out_empty;
    bwls_pkg::t_weight r_min_weight;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_slot_free;
    logic               w_row_ok;
    logic               w_col_ok;
    logic               w_issue;
    logic               w_last;
    bwls_pkg::t_addr    w_load_addr;
    bwls_pkg::t_addr    w_row_base;
    logic               w_ram_we;
    bwls_pkg::t_addr    w_ram_waddr;
    bwls_pkg::t_weight  w_ram_wdata;
    bwls_pkg::t_addr    w_ram_raddr;
    bwls_pkg::t_weight  w_ram_rdata;
    bwls_pkg::t_word    w_shifted;
    bwls_pkg::t_alu_req w_alu_req;
    bwls_pkg::t_word    w_alu_res;
    logic               w_alu_borrow;

    // Handshakes and decode
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != bwls_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_vld && !i_out_stall;
    assign w_slot_free = !r_out_vld || !i_out_stall;
    assign w_row_ok    = 32'(i_row) < bwls_pkg::ROWS;
    assign w_col_ok    = 32'(i_column) < bwls_pkg::ALPHABET;
    assign w_row_base  = bwls_pkg::t_addr'(32'(i_row) * bwls_pkg::ALPHABET);
    assign w_load_addr = bwls_pkg::t_addr'(32'(i_row) * bwls_pkg::ALPHABET
                                           + 32'(i_column));
    assign w_issue     = ((r_state == bwls_pkg::ST_SUM) || (r_state == bwls_pkg::ST_SCAN))
                         && (r_cnt < bwls_pkg::CNT_END);
    assign w_last      = (r_rd_idx == bwls_pkg::LAST_IDX);
    assign w_shifted   = {r_rem[bwls_pkg::TOT_W-1:0], r_rnd[bwls_pkg::RAND_W-1]};

    bwls_ram #(
        .WIDTH (bwls_pkg::WEIGHT_W),
        .DEPTH (bwls_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bwls_alu u_alu (
        .i_req    (w_alu_req),
        .o_result (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bwls_pkg::ST_CLEAR: begin
                if (r_clr_addr == bwls_pkg::CLR_LAST) begin
                    n_state = bwls_pkg::ST_IDLE;
                end
            end
            bwls_pkg::ST_IDLE: begin
                if (w_in_acc && (i_command == bwls_pkg::CMD_DRAW)) begin
                    n_state = w_row_ok ? bwls_pkg::ST_SUM : bwls_pkg::ST_DONE;
                end
            end
            bwls_pkg::ST_SUM: begin
                if (r_rd_vld && w_last) begin
                    n_state = (w_alu_res == '0) ? bwls_pkg::ST_DONE : bwls_pkg::ST_DIV;
                end
            end
            bwls_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = bwls_pkg::ST_SCAN;
                end
            end
            bwls_pkg::ST_SCAN: begin
                if (r_rd_vld && (w_alu_borrow || w_last)) begin
                    n_state = bwls_pkg::ST_DONE;
                end
            end
            bwls_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_state = bwls_pkg::ST_IDLE;
                end
            end
            default: n_state = bwls_pkg::ST_CLEAR;
        endcase
    end

    // Table port and shared unit control
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_load_addr;
        w_ram_wdata = (i_weight < r_min_weight) ? '0 : i_weight;
        w_ram_raddr = w_issue ? (r_base + bwls_pkg::t_addr'(r_cnt)) : r_base;
        w_alu_req   = '{op: bwls_pkg::ALU_ADD, a: r_acc,
                        b: bwls_pkg::t_word'(w_ram_rdata)};
        case (r_state)
            bwls_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            bwls_pkg::ST_IDLE: begin
                w_ram_we = w_in_acc && (i_command == bwls_pkg::CMD_LOAD)
                           && w_row_ok && w_col_ok;
            end
            bwls_pkg::ST_DIV: begin
                w_alu_req = '{op: bwls_pkg::ALU_SUB, a: w_shifted, b: r_acc};
            end
            bwls_pkg::ST_SCAN: begin
                w_alu_req = '{op: bwls_pkg::ALU_SUB, a: r_rem,
                              b: bwls_pkg::t_word'(w_ram_rdata)};
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_rd_idx    = r_cnt;
        n_rd_vld    = w_issue;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_rnd       = r_rnd;
        n_bit       = r_bit;
        n_pick      = r_pick;
        n_empty     = r_empty;
        n_out_vld   = r_out_vld && !w_out_acc;
        n_letter    = r_letter;
        n_out_empty = r_out_empty;
        if (w_issue) begin
            n_cnt = r_cnt + 1'b1;
        end
        case (r_state)
            bwls_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
            bwls_pkg::ST_IDLE: begin
                // start a draw: row above the table reads as empty
                if (w_in_acc && (i_command == bwls_pkg::CMD_DRAW)) begin
                    n_base  = w_row_base;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rnd   = i_random_value;
                    n_pick  = '0;
                    n_empty = 1'b1;
                end
            end
            bwls_pkg::ST_SUM: begin
                if (r_rd_vld) begin
                    n_acc = w_alu_res;
                    if (w_last) begin
                        n_rem   = '0;
                        n_bit   = bwls_pkg::BIT_LAST;
                        n_empty = (w_alu_res == '0);
                    end
                end
            end
            bwls_pkg::ST_DIV: begin
                // one restoring step per cycle
                n_rem = w_alu_borrow ? w_shifted : w_alu_res;
                n_rnd = r_rnd << 1;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_cnt    = '0;
                    n_rd_vld = 1'b0;
                end
            end
            bwls_pkg::ST_SCAN: begin
                // stop at the first weight larger than what is left, or at the last letter
                if (r_rd_vld) begin
                    if (w_alu_borrow || w_last) begin
                        n_pick  = r_rd_idx;
                        n_empty = 1'b0;
                    end else begin
                        n_rem = w_alu_res;
                    end
                end
            end
            bwls_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_out_vld   = 1'b1;
                    n_letter    = bwls_pkg::t_letter'(r_pick);
                    n_out_empty = r_empty;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bwls_pkg::ST_CLEAR;
            r_clr_addr   <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_min_weight <= bwls_pkg::MIN_WEIGHT_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_weight <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_cnt       <= n_cnt;
        r_rd_idx    <= n_rd_idx;
        r_acc       <= n_acc;
        r_rem       <= n_rem;
        r_rnd       <= n_rnd;
        r_bit       <= n_bit;
        r_pick      <= n_pick;
        r_empty     <= n_empty;
        r_letter    <= n_letter;
        r_out_empty <= n_out_empty;
    end

    assign o_out_valid = r_out_vld;
    assign o_letter    = r_letter;
    assign o_empty_row = r_out_empty;

    // Remainder stays below the row total while dividing
    a_rem_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwls_pkg::ST_DIV) |-> (r_rem < r_acc))
        else $error("modulo remainder not below row total");

    // What is left of the target stays below the row total while scanning
    a_rem_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwls_pkg::ST_SCAN) |-> (r_rem < r_acc))
        else $error("scan target not below row total");

    // No table write while a draw is reading the row
    a_no_write_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bwls_pkg::ST_SUM) || (r_state == bwls_pkg::ST_DIV)
         || (r_state == bwls_pkg::ST_SCAN)) |-> !w_ram_we)
        else $error("table written during a draw");

    // A new result only comes from the final draw state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == bwls_pkg::ST_DONE))
        else $error("result raised outside the final state");

    // An empty row answers letter zero
    a_empty_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_empty) |-> (r_letter == '0))
        else $error("empty row with nonzero letter");

endmodule
